[rtl/core/beaq_pkg.sv]
// Shared types, button masks and palette step functions for the button qualifier.
`default_nettype none
package beaq_pkg;

   localparam int unsigned BtnWidth   = 10;
   localparam int unsigned MsWidth    = 16;
   localparam int unsigned HoldWidth  = 17;
   localparam int unsigned PalWidth   = 7;
   localparam int unsigned IdxWidth   = 6;
   localparam int unsigned CsrAddrWidth = 5;
   localparam int unsigned CsrDataWidth = 32;

   // Button positions in the button word.
   localparam int unsigned BtnA      = 0;
   localparam int unsigned BtnB      = 1;
   localparam int unsigned BtnSelect = 2;
   localparam int unsigned BtnUp     = 4;
   localparam int unsigned BtnDown   = 5;
   localparam int unsigned BtnLeft   = 6;
   localparam int unsigned BtnRight  = 7;

   localparam logic [BtnWidth-1:0] BtnDirsMask = 10'b00_1111_0000;
   localparam logic [HoldWidth-1:0] HoldMax = '1;
   localparam logic [PalWidth-1:0] PalMax = 7'd64;

   // Register indexes on the configuration port.
   localparam logic [2:0] CSR_LONG_PRESS   = 3'd0;
   localparam logic [2:0] CSR_REPEAT_DELAY = 3'd1;
   localparam logic [2:0] CSR_PALETTE_SIZE = 3'd2;
   localparam logic [2:0] CSR_DEFAULT_FG   = 3'd3;
   localparam logic [2:0] CSR_DEFAULT_BG   = 3'd4;

   localparam logic [MsWidth-1:0]  LongPressReset   = 16'd500;
   localparam logic [MsWidth-1:0]  RepeatDelayReset = 16'd40;
   localparam logic [PalWidth-1:0] PaletteSizeReset = 7'd64;
   localparam logic [IdxWidth-1:0] DefaultFgReset   = 6'd0;
   localparam logic [IdxWidth-1:0] DefaultBgReset   = 6'd0;

   typedef struct packed {
      logic [MsWidth-1:0]  long_press_ms;
      logic [MsWidth-1:0]  repeat_delay_ms;
      logic [PalWidth-1:0] palette_size;
      logic [IdxWidth-1:0] default_fg;
      logic [IdxWidth-1:0] default_bg;
   } cfg_type;

   typedef struct packed {
      logic [BtnWidth-1:0]  previous_buttons;
      logic [HoldWidth-1:0] hold_timer;
      logic [IdxWidth-1:0]  fg_colour;
      logic [IdxWidth-1:0]  bg_colour;
   } state_type;

   typedef struct packed {
      logic [BtnWidth-1:0] buttons;
      logic [MsWidth-1:0]  elapsed_ms;
      logic                ignore_edges;
   } poll_type;

   typedef struct packed {
      logic [BtnWidth-1:0] pad_bits;
      logic                wake;
      logic [IdxWidth-1:0] fg_index;
      logic [IdxWidth-1:0] bg_index;
      logic                colours_changed;
      logic                save_request;
   } result_type;

   // Palette size clamped into 1..64.
   function automatic logic [PalWidth-1:0] eff_size(input logic [PalWidth-1:0] size);
      logic [PalWidth-1:0] s;
      if (size == '0) begin
         s = 7'd1;
      end else if (size > PalMax) begin
         s = PalMax;
      end else begin
         s = size;
      end
      return s;
   endfunction

   function automatic logic [IdxWidth-1:0] step_up(input logic [IdxWidth-1:0] idx,
                                                   input logic [PalWidth-1:0] size);
      logic [PalWidth-1:0] n;
      logic [IdxWidth-1:0] r;
      n = {1'b0, idx} + 7'd1;
      if (n >= eff_size(size)) begin
         r = '0;
      end else begin
         r = n[IdxWidth-1:0];
      end
      return r;
   endfunction

   function automatic logic [IdxWidth-1:0] step_down(input logic [IdxWidth-1:0] idx,
                                                     input logic [PalWidth-1:0] size);
      logic [PalWidth-1:0] top;
      logic [IdxWidth-1:0] r;
      top = eff_size(size) - 7'd1;
      if (idx == '0) begin
         r = top[IdxWidth-1:0];
      end else begin
         r = idx - 6'd1;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[rtl/core/beaq_step.sv]
// Next-state and result logic for one poll of the button qualifier.
`default_nettype none
module beaq_step
   import beaq_pkg::*;
(
   input  wire cfg_type    cfg,
   input  wire state_type  state,
   input  wire poll_type   poll,
   output state_type       state_next,
   output result_type      result
);

   logic [HoldWidth:0]    hold_sum;
   logic [HoldWidth-1:0]  hold_acc;
   logic [BtnWidth-1:0]   pushed;
   logic [BtnWidth-1:0]   word;
   logic                  select;
   logic                  fire;
   logic [IdxWidth-1:0]   fg_next;
   logic [IdxWidth-1:0]   bg_next;
   logic                  changed;
   logic                  save;
   logic [MsWidth-1:0]    reload;

   assign hold_sum = {1'b0, state.hold_timer} + {{(HoldWidth+1-MsWidth){1'b0}}, poll.elapsed_ms};

   always_comb begin
      if ((poll.buttons & BtnDirsMask) != '0) begin
         hold_acc = hold_sum[HoldWidth] ? HoldMax : hold_sum[HoldWidth-1:0];
      end else begin
         hold_acc = '0;
      end
   end

   assign pushed = poll.ignore_edges ? poll.buttons : (poll.buttons & ~state.previous_buttons);
   assign select = poll.buttons[BtnSelect];
   assign word   = select ? '0 : poll.buttons;
   assign fire   = (pushed != '0) ||
                   (hold_acc > {{(HoldWidth-MsWidth){1'b0}}, cfg.long_press_ms});
   assign reload = (cfg.repeat_delay_ms > cfg.long_press_ms) ? '0
                   : cfg.long_press_ms - cfg.repeat_delay_ms;

   // While SELECT is held, only the first newly pressed button in the order UP, DOWN, LEFT, RIGHT, A, B acts.
   always_comb begin
      fg_next = state.fg_colour;
      bg_next = state.bg_colour;
      changed = 1'b0;
      save    = 1'b0;
      if (select) begin
         priority if (pushed[BtnUp]) begin
            fg_next = step_up(state.fg_colour, cfg.palette_size);
            changed = 1'b1;
         end else if (pushed[BtnDown]) begin
            fg_next = step_down(state.fg_colour, cfg.palette_size);
            changed = 1'b1;
         end else if (pushed[BtnLeft]) begin
            bg_next = step_up(state.bg_colour, cfg.palette_size);
            changed = 1'b1;
         end else if (pushed[BtnRight]) begin
            bg_next = step_down(state.bg_colour, cfg.palette_size);
            changed = 1'b1;
         end else if (pushed[BtnA]) begin
            save = 1'b1;
         end else if (pushed[BtnB]) begin
            fg_next = cfg.default_fg;
            bg_next = cfg.default_bg;
            changed = 1'b1;
            save    = 1'b1;
         end else begin
            save = 1'b0;
         end
      end
   end

   always_comb begin
      state_next.previous_buttons = poll.buttons;
      state_next.fg_colour        = fg_next;
      state_next.bg_colour        = bg_next;
      // A repeat with no new press restarts the timer one repeat interval short of the limit.
      if (fire && (pushed == '0)) begin
         state_next.hold_timer = {{(HoldWidth-MsWidth){1'b0}}, reload};
      end else begin
         state_next.hold_timer = hold_acc;
      end
   end

   always_comb begin
      result.pad_bits        = fire ? word : '0;
      result.wake            = select || (fire && (word != '0));
      result.fg_index        = fg_next;
      result.bg_index        = bg_next;
      result.colours_changed = changed;
      result.save_request    = save;
   end

endmodule
`default_nettype wire

[rtl/core/button_edge_autorepeat_qualifier.sv]
// Top level of the button qualifier: poll handshake, registers and result staging.
// The req channel takes one poll word per handshake: held buttons, the milliseconds
// since the previous poll and a flag that treats every held button as new. For each
// poll the rsp channel returns exactly one word: the qualified button word, a wake
// flag, the current palette indices and the colour change and save flags.
// A poll accepted into the input register is evaluated against the hold timer, edge
// and palette state, and its result is captured in the result register, which
// drives rsp_valid, once that register is empty or its word is being taken.
// With rsp_ready high, throughput is one word per cycle; the input and result
// registers each hold a word, so a new poll is taken while a finished result waits.
// When rsp_ready is low the result register holds its word, the input register
// fills, and req_ready drops only once both are full.
// Reset clears both stages, the previous-button word and the hold timer, sets the
// colour indices to the default index reset values and the registers to their
// reset values. Register writes on the APB port are registered at the end of the access
// cycle; they are expected only while no poll is in flight.
`default_nettype none
module button_edge_autorepeat_qualifier
   import beaq_pkg::*;
(
   input  wire                      clock,
   input  wire                      reset,

   input  wire                      req_valid,
   output logic                     req_ready,
   input  wire  [BtnWidth-1:0]      req_buttons,
   input  wire  [MsWidth-1:0]       req_elapsed_ms,
   input  wire                      req_ignore_edges,

   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output logic [BtnWidth-1:0]      rsp_pad_bits,
   output logic                     rsp_wake,
   output logic [IdxWidth-1:0]      rsp_fg_index,
   output logic [IdxWidth-1:0]      rsp_bg_index,
   output logic                     rsp_colours_changed,
   output logic                     rsp_save_request,

   input  wire                      csr_psel,
   input  wire                      csr_penable,
   input  wire                      csr_pwrite,
   input  wire  [CsrAddrWidth-1:0]  csr_paddr,
   input  wire  [CsrDataWidth-1:0]  csr_pwdata,
   output logic [CsrDataWidth-1:0]  csr_prdata,
   output logic                     csr_pready
);

   cfg_type    cfg_ff, cfg_in;
   state_type  state_ff, state_in, state_next;
   poll_type   poll_ff, poll_in;
   logic       poll_valid_ff, poll_valid_in;
   result_type result_ff, result_in, result_next;
   logic       result_valid_ff, result_valid_in;
   logic       advance;
   logic       csr_write;
   logic [2:0] csr_index;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[CsrAddrWidth-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_LONG_PRESS:   cfg_in.long_press_ms   = csr_pwdata[MsWidth-1:0];
            CSR_REPEAT_DELAY: cfg_in.repeat_delay_ms = csr_pwdata[MsWidth-1:0];
            CSR_PALETTE_SIZE: cfg_in.palette_size    = csr_pwdata[PalWidth-1:0];
            CSR_DEFAULT_FG:   cfg_in.default_fg      = csr_pwdata[IdxWidth-1:0];
            CSR_DEFAULT_BG:   cfg_in.default_bg      = csr_pwdata[IdxWidth-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_LONG_PRESS:   csr_prdata = {{(CsrDataWidth-MsWidth){1'b0}}, cfg_ff.long_press_ms};
         CSR_REPEAT_DELAY: csr_prdata = {{(CsrDataWidth-MsWidth){1'b0}}, cfg_ff.repeat_delay_ms};
         CSR_PALETTE_SIZE: csr_prdata = {{(CsrDataWidth-PalWidth){1'b0}}, cfg_ff.palette_size};
         CSR_DEFAULT_FG:   csr_prdata = {{(CsrDataWidth-IdxWidth){1'b0}}, cfg_ff.default_fg};
         CSR_DEFAULT_BG:   csr_prdata = {{(CsrDataWidth-IdxWidth){1'b0}}, cfg_ff.default_bg};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ms   <= LongPressReset;
         cfg_ff.repeat_delay_ms <= RepeatDelayReset;
         cfg_ff.palette_size    <= PaletteSizeReset;
         cfg_ff.default_fg      <= DefaultFgReset;
         cfg_ff.default_bg      <= DefaultBgReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------- poll pipeline ----------------
   // A registered poll moves into the result register whenever that register is
   // empty or its word is being taken; the state advances with it.
   assign advance   = poll_valid_ff && (!result_valid_ff || rsp_ready);
   assign req_ready = !poll_valid_ff || advance;

   always_comb begin
      poll_valid_in = poll_valid_ff;
      poll_in       = poll_ff;
      if (req_valid && req_ready) begin
         poll_valid_in        = 1'b1;
         poll_in.buttons      = req_buttons;
         poll_in.elapsed_ms   = req_elapsed_ms;
         poll_in.ignore_edges = req_ignore_edges;
      end else if (advance) begin
         poll_valid_in = 1'b0;
      end
   end

   beaq_step u_step (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .poll       (poll_ff),
      .state_next (state_next),
      .result     (result_next)
   );

   assign state_in = advance ? state_next : state_ff;

   always_comb begin
      result_in       = result_ff;
      result_valid_in = result_valid_ff;
      if (advance) begin
         result_in       = result_next;
         result_valid_in = 1'b1;
      end else if (rsp_ready) begin
         result_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_valid_ff             <= 1'b0;
         result_valid_ff           <= 1'b0;
         state_ff.previous_buttons <= '0;
         state_ff.hold_timer       <= '0;
         state_ff.fg_colour        <= DefaultFgReset;
         state_ff.bg_colour        <= DefaultBgReset;
      end else begin
         poll_valid_ff   <= poll_valid_in;
         result_valid_ff <= result_valid_in;
         state_ff        <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      poll_ff   <= poll_in;
      result_ff <= result_in;
   end

   assign rsp_valid           = result_valid_ff;
   assign rsp_pad_bits        = result_ff.pad_bits;
   assign rsp_wake            = result_ff.wake;
   assign rsp_fg_index        = result_ff.fg_index;
   assign rsp_bg_index        = result_ff.bg_index;
   assign rsp_colours_changed = result_ff.colours_changed;
   assign rsp_save_request    = result_ff.save_request;

endmodule
`default_nettype wire
